[rtl/core/assert_macros.svh]
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr), msg)

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[rtl/core/mm2_pkg.sv]
package mm2_pkg;

    localparam int WORD_W = 32;
    localparam int VB_W   = 3;
    localparam int LEN_W  = 31;

    localparam logic [WORD_W-1:0] MIX_MUL = 32'h5bd1e995;
    localparam int MIX_SHIFT   = 24;
    localparam int FIN_SHIFT_A = 13;
    localparam int FIN_SHIFT_B = 15;

    localparam logic [WORD_W-1:0] SEED_RESET = '0;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [VB_W-1:0]   valid_bytes;
        logic              last_word;
        logic [LEN_W-1:0]  key_length;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W1,
        ST_W2,
        ST_H,
        ST_HX,
        ST_T,
        ST_TX,
        ST_F1,
        ST_F2
    } state_t;

    function automatic logic [WORD_W-1:0] tail_mask(input logic [1:0] nbytes);
        logic [WORD_W-1:0] m;
        unique case (nbytes)
            2'd1:    m = 32'h0000_00ff;
            2'd2:    m = 32'h0000_ffff;
            2'd3:    m = 32'h00ff_ffff;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/mm2_mul.sv]
module mm2_mul
    import mm2_pkg::*;
(
    input  logic              aclk,
    input  logic              en_i,
    input  logic [WORD_W-1:0] op_i,
    output logic [WORD_W-1:0] prod_o
);

    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] prod_next;

    assign prod_next = op_i * MIX_MUL;

    always_ff @(posedge aclk) begin
        if (en_i) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_o = prod_reg;

endmodule

[rtl/core/mm2_seq.sv]
`include "assert_macros.svh"

module mm2_seq
    import mm2_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [WORD_W-1:0] seed_i,
    input  item_t             item_i,
    input  logic              item_valid_i,
    output logic              item_ready_o,
    output logic              res_valid_o,
    input  logic              res_ready_i,
    output logic [WORD_W-1:0] res_hash_o,
    output logic              mul_en_o,
    output logic [WORD_W-1:0] mul_op_o,
    input  logic [WORD_W-1:0] mul_prod_i
);

    state_t            state_reg, state_next;
    logic              inside_reg, inside_next;
    logic              last_reg, last_next;
    logic [WORD_W-1:0] h_reg, h_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [WORD_W-1:0] h_start;
    logic              is_tail;
    logic              item_fire;
    logic              res_fire;

    assign h_start = inside_reg ? h_reg : (seed_i ^ {1'b0, item_i.key_length});
    assign is_tail = item_i.last_word && (item_i.valid_bytes < 3'd4);
    assign item_fire = item_valid_i && item_ready_o;
    assign res_fire  = res_valid_o && res_ready_i;
    assign res_hash_o = mul_prod_i ^ (mul_prod_i >> FIN_SHIFT_B);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            inside_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg    <= h_next;
        w_reg    <= w_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next   = state_reg;
        inside_next  = inside_reg;
        last_next    = last_reg;
        h_next       = h_reg;
        w_next       = w_reg;
        item_ready_o = 1'b0;
        res_valid_o  = 1'b0;
        mul_en_o     = 1'b0;
        mul_op_o     = w_reg;
        unique case (state_reg)
            ST_IDLE: begin
                item_ready_o = 1'b1;
                if (item_valid_i) begin
                    w_next    = item_i.data_word;
                    last_next = item_i.last_word;
                    if (!is_tail) begin
                        h_next     = h_start;
                        state_next = ST_W1;
                    end else if (item_i.valid_bytes == 3'd0) begin
                        h_next     = h_start;
                        state_next = ST_F1;
                    end else begin
                        h_next     = h_start ^ (item_i.data_word
                                              & tail_mask(item_i.valid_bytes[1:0]));
                        state_next = ST_T;
                    end
                end
            end
            ST_W1: begin
                mul_en_o   = 1'b1;
                mul_op_o   = w_reg;
                state_next = ST_W2;
            end
            ST_W2: begin
                w_next     = mul_prod_i ^ (mul_prod_i >> MIX_SHIFT);
                mul_en_o   = 1'b1;
                mul_op_o   = h_reg;
                state_next = ST_H;
            end
            ST_H: begin
                h_next     = mul_prod_i;
                mul_en_o   = 1'b1;
                mul_op_o   = w_reg;
                state_next = ST_HX;
            end
            ST_HX: begin
                h_next = h_reg ^ mul_prod_i;
                if (last_reg) begin
                    state_next = ST_F1;
                end else begin
                    inside_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_T: begin
                mul_en_o   = 1'b1;
                mul_op_o   = h_reg;
                state_next = ST_TX;
            end
            ST_TX: begin
                h_next     = mul_prod_i;
                state_next = ST_F1;
            end
            ST_F1: begin
                mul_en_o   = 1'b1;
                mul_op_o   = h_reg ^ (h_reg >> FIN_SHIFT_A);
                state_next = ST_F2;
            end
            ST_F2: begin
                res_valid_o = 1'b1;
                if (res_ready_i) begin
                    inside_next = 1'b0;
                    h_next      = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, item_fire |=> !item_ready_o, "accepted while busy")
    `ASSERT_CLK(a_key_closed, aclk, aresetn, res_fire |=> !inside_reg, "key still open after result")
    `ASSERT_CLK(a_word_mixed, aclk, aresetn, (item_fire && !item_i.last_word) |-> ##5 (inside_reg && state_reg == ST_IDLE), "full word not mixed in time")

endmodule

[rtl/core/murmur2_hash_32.sv]
// Channel  Direction  Signals
// s_       in         s_valid s_ready s_data_word s_valid_bytes s_last_word s_key_length
// m_       out        m_valid m_ready m_hash_value
// cfg_     in         cfg_valid cfg_ready cfg_data (seed)
//
// One shared 32x32 multiplier with a registered product sets the pace.
// Accept to next ready (s_ready only in idle): a full word runs W1, W2, H, HX, then
// F1 and F2 if last; a last word of 1 to 3 bytes T, TX, F1, F2; an empty one F1, F2.
// Synchronous active-low reset clears the sequencer and the output slot, loads SEED_INIT.
// A finished hash waits in the output register; a new key starts meanwhile.
module murmur2_hash_32
    import mm2_pkg::*;
#(
    parameter logic [WORD_W-1:0] SEED_INIT = SEED_RESET
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_data_word,
    input  logic [VB_W-1:0]   s_valid_bytes,
    input  logic              s_last_word,
    input  logic [LEN_W-1:0]  s_key_length,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_hash_value
);

    logic [WORD_W-1:0] seed_reg, seed_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_hash_reg, m_hash_next;
    item_t             item;
    logic              res_valid;
    logic              res_ready;
    logic [WORD_W-1:0] res_hash;
    logic              mul_en;
    logic [WORD_W-1:0] mul_op;
    logic [WORD_W-1:0] mul_prod;

    assign cfg_ready = 1'b1;
    assign seed_next = (cfg_valid && cfg_ready) ? cfg_data : seed_reg;

    assign item.data_word   = s_data_word;
    assign item.valid_bytes = s_valid_bytes;
    assign item.last_word   = s_last_word;
    assign item.key_length  = s_key_length;

    assign res_ready    = !m_valid_reg || m_ready;
    assign m_valid_next = res_valid ? 1'b1 : (m_valid_reg && !m_ready);
    assign m_hash_next  = (res_valid && res_ready) ? res_hash : m_hash_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= SEED_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            seed_reg    <= seed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hash_reg <= m_hash_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    mm2_mul u_mul (
        .aclk   (aclk),
        .en_i   (mul_en),
        .op_i   (mul_op),
        .prod_o (mul_prod)
    );

    mm2_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .seed_i       (seed_reg),
        .item_i       (item),
        .item_valid_i (s_valid),
        .item_ready_o (s_ready),
        .res_valid_o  (res_valid),
        .res_ready_i  (res_ready),
        .res_hash_o   (res_hash),
        .mul_en_o     (mul_en),
        .mul_op_o     (mul_op),
        .mul_prod_i   (mul_prod)
    );

endmodule
